FILE: hdl/tdpc_pkg.sv
// Package for the trial-division prime counter.
// Field widths, transaction payload structs and divider status type.
// No dependencies.
`default_nettype none

package tdpc_pkg;

    localparam int VALUE_BITS = 31;
    localparam int DIV_BITS   = VALUE_BITS / 2 + 1;
    localparam int SQ_BITS    = 2 * DIV_BITS;
    localparam int CNT_BITS   = $clog2(VALUE_BITS);

    typedef struct packed {
        logic [VALUE_BITS-1:0] candidate;
        logic                  clear_count;
    } tdpc_in_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] tested_value;
        logic                  prime_flag;
        logic [VALUE_BITS-1:0] prime_total;
    } tdpc_out_t;

    typedef struct packed {
        logic done;
        logic zero;
    } tdpc_rem_status_t;

endpackage

`default_nettype wire

FILE: hdl/tdpc_rem.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on tdpc_pkg.
`default_nettype none

module tdpc_rem (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [tdpc_pkg::VALUE_BITS-1:0] dividend,
    input  wire logic [tdpc_pkg::DIV_BITS-1:0]   divisor,
    output tdpc_pkg::tdpc_rem_status_t           status
);
    import tdpc_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [VALUE_BITS-1:0] shift_reg, shift_next;
    logic [DIV_BITS-1:0]   rem_reg, rem_next;
    logic [DIV_BITS-1:0]   div_reg, div_next;
    logic [DIV_BITS:0]     trial;
    logic [DIV_BITS:0]     diff;

    assign trial = {rem_reg, shift_reg[VALUE_BITS-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = CNT_BITS'(VALUE_BITS - 1);
            shift_next = dividend;
            rem_next   = '0;
            div_next   = divisor;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[VALUE_BITS-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
                rem_next = diff[DIV_BITS-1:0];
            else
                rem_next = trial[DIV_BITS-1:0];
            count_next = count_reg - 1'b1;
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
    end

    assign status.done = done_reg;
    assign status.zero = (rem_reg == '0);

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("remainder done while still busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("start did not begin a division");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !start)
        else $error("start while division in progress");

endmodule

`default_nettype wire

FILE: hdl/trial_division_prime_counter_core.sv
// Candidates below 2 go straight to ST_FINISH; else each divisor tried takes a bound check,
// VALUE_BITS remainder steps and a verdict; a prime ends on one more bound check.
// Throughput: one transaction at a time; the bit-serial remainder unit sets the rate.
// A new input is taken while a finished result waits in the output register.
// Reset (rst_n, async, active low) clears the prime count, the FSM and output valid.
// Depends on tdpc_pkg and tdpc_rem.
`default_nettype none

module trial_division_prime_counter_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire tdpc_pkg::tdpc_in_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output tdpc_pkg::tdpc_out_t      out_data
);
    import tdpc_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_BOUND  = 5'b00010,
        ST_DIVIDE = 5'b00100,
        ST_FINISH = 5'b01000,
        ST_WAIT   = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic [VALUE_BITS-1:0] cand_reg, cand_next;
    logic [DIV_BITS-1:0]   divisor_reg, divisor_next;
    logic [SQ_BITS-1:0]    sq_reg, sq_next;
    logic                  prime_reg, prime_next;
    logic [VALUE_BITS-1:0] tally_reg, tally_next;
    logic                  out_valid_reg, out_valid_next;
    tdpc_out_t             out_reg, out_next;
    logic                  rem_start;
    tdpc_rem_status_t      rem_status;
    logic                  in_fire;
    logic                  out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    tdpc_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (cand_reg),
        .divisor  (divisor_reg),
        .status   (rem_status)
    );

    always_comb
    begin
        state_next     = state_reg;
        cand_next      = cand_reg;
        divisor_next   = divisor_reg;
        sq_next        = sq_reg;
        prime_next     = prime_reg;
        tally_next     = tally_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        rem_start      = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cand_next    = in_data.candidate;
                    divisor_next = DIV_BITS'(2);
                    sq_next      = SQ_BITS'(4);
                    prime_next   = 1'b0;
                    if (in_data.clear_count)
                        tally_next = '0;
                    if (in_data.candidate < VALUE_BITS'(2))
                        state_next = ST_FINISH;
                    else
                        state_next = ST_BOUND;
                end
            end
            ST_BOUND:
            begin
                if (sq_reg > SQ_BITS'(cand_reg))
                begin
                    prime_next = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    rem_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (rem_status.done)
                begin
                    if (rem_status.zero)
                        state_next = ST_FINISH;
                    else
                    begin
                        sq_next      = sq_reg + SQ_BITS'({divisor_reg, 1'b1});
                        divisor_next = divisor_reg + 1'b1;
                        state_next   = ST_BOUND;
                    end
                end
            end
            ST_FINISH:
            begin
                if (prime_reg && (tally_reg != '1))
                    tally_next = tally_reg + 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (out_free)
                begin
                    out_next.tested_value = cand_reg;
                    out_next.prime_flag   = prime_reg;
                    out_next.prime_total  = tally_reg;
                    out_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tally_reg     <= tally_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg    <= cand_next;
        divisor_reg <= divisor_next;
        sq_reg      <= sq_next;
        prime_reg   <= prime_next;
        out_reg     <= out_next;
    end

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_prime_ge_two: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.prime_flag) |-> (out_reg.tested_value >= VALUE_BITS'(2)))
        else $error("value below two reported prime");

    a_divisor_min: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BOUND || state_reg == ST_DIVIDE) |-> (divisor_reg >= DIV_BITS'(2)))
        else $error("trial divisor below two");

    a_tally_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |=> (tally_reg == $past(tally_reg)
            || tally_reg == $past(tally_reg) + 1'b1))
        else $error("prime count moved by more than one");

endmodule

`default_nettype wire
